// ===== design/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, codes and defaults for the power-of-two block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int LOG_BLOCKS_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 64;

  localparam int SIZE_W   = 17;
  localparam int INDEX_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd3;

  typedef struct packed {
    logic               op;
    logic [SIZE_W-1:0]  size_blocks;
    logic [INDEX_W-1:0] first_block;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  block_index;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

// ===== design/pba_alu.sv =====
// ----------------------------------------------------------------------------
// pba_alu
// Shared add/subtract unit with an upper-limit compare on the result.
// ----------------------------------------------------------------------------
module pba_alu #(
  parameter int AW = 18
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  input  logic [AW-1:0] lim,
  output logic [AW-1:0] res,
  output logic          fits
);

  assign res  = sub ? (a - b) : (a + b);
  assign fits = (res <= lim);

endmodule

// ===== design/pba_store.sv =====
// ----------------------------------------------------------------------------
// pba_store
// Per-order free chunk stacks: chunk memory, fill counts and pool order.
// ----------------------------------------------------------------------------
module pba_store import pba_pkg::*; #(
  parameter int LOG_BLOCKS  = LOG_BLOCKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int NUM_ORDERS = LOG_BLOCKS + 1,
  localparam int OW         = $clog2(NUM_ORDERS),
  localparam int CW         = $clog2(STACK_DEPTH + 1),
  localparam int IW         = $clog2(STACK_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pool_order_we,
  input  logic [CFG_W-1:0]      pool_order_wdata,
  input  stk_cmd_t              cmd,
  input  logic [OW-1:0]         order,
  input  logic [LOG_BLOCKS-1:0] wdata,
  output logic [CW-1:0]         count,
  output logic [LOG_BLOCKS-1:0] rdata,
  output logic [OW-1:0]         pool_order
);

  logic [CW-1:0]         counts [NUM_ORDERS];
  logic [LOG_BLOCKS-1:0] mem [NUM_ORDERS][STACK_DEPTH];
  logic                  fresh;
  logic                  rd_zero;
  logic [LOG_BLOCKS-1:0] rd_raw;
  logic [OW-1:0]         po_sat;
  logic [CW-1:0]         cnt_dec;
  logic                  full;

  assign count   = counts[order];
  assign cnt_dec = count - CW'(1);
  assign full    = (count == CW'(STACK_DEPTH));
  assign rdata   = rd_zero ? '0 : rd_raw;
  assign po_sat  = (pool_order_wdata > CFG_W'(LOG_BLOCKS)) ? OW'(LOG_BLOCKS)
                                                            : pool_order_wdata[OW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < NUM_ORDERS; o++) begin
        counts[o] <= (o == LOG_BLOCKS) ? CW'(1) : '0;
      end
      fresh      <= 1'b1;
      pool_order <= OW'(LOG_BLOCKS);
    end else if (pool_order_we) begin
      for (int o = 0; o < NUM_ORDERS; o++) begin
        counts[o] <= (OW'(o) == po_sat) ? CW'(1) : '0;
      end
      fresh      <= 1'b1;
      pool_order <= po_sat;
    end else begin
      if (cmd.pop) begin
        counts[order] <= cnt_dec;
      end
      if (cmd.push && !full) begin
        counts[order] <= count + CW'(1);
        if (order == pool_order && count == '0) begin
          fresh <= 1'b0;
        end
      end
    end
  end

  // initial top chunk at block zero is never written, it reads as zero
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[order][count[IW-1:0]] <= wdata;
    end
    if (cmd.pop) begin
      rd_raw  <= mem[order][cnt_dec[IW-1:0]];
      rd_zero <= fresh && (order == pool_order) && (count == CW'(1));
    end
  end

endmodule

// ===== design/pba_seq.sv =====
// ----------------------------------------------------------------------------
// pba_seq
// Sequencer: order scan, pop and split for allocate, aligned cuts for free.
// ----------------------------------------------------------------------------
module pba_seq import pba_pkg::*; #(
  parameter int LOG_BLOCKS  = LOG_BLOCKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int OW         = $clog2(LOG_BLOCKS + 1),
  localparam int CW         = $clog2(STACK_DEPTH + 1),
  localparam int AW         = (LOG_BLOCKS + 1 > SIZE_W + 1) ? LOG_BLOCKS + 1 : SIZE_W + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic [OW-1:0]         pool_order,
  input  logic [CW-1:0]         count,
  input  logic [LOG_BLOCKS-1:0] rdata,
  output stk_cmd_t              cmd,
  output logic [OW-1:0]         order,
  output logic [LOG_BLOCKS-1:0] wdata,
  output logic [AW-1:0]         alu_a,
  output logic [AW-1:0]         alu_b,
  output logic                  alu_sub,
  output logic [AW-1:0]         alu_lim,
  input  logic [AW-1:0]         alu_res,
  input  logic                  alu_fits
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_REST  = 3'd4;
  localparam logic [2:0] S_SPLIT = 3'd5;
  localparam logic [2:0] S_UP    = 3'd6;
  localparam logic [2:0] S_DOWN  = 3'd7;

  logic [2:0]            state;
  logic                  op;
  logic [SIZE_W-1:0]     size;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         lim;
  logic [OW-1:0]         idx;
  logic                  dropped;
  logic [LOG_BLOCKS-1:0] blk;

  logic [AW-1:0] bit_val;
  logic [AW-1:0] pool_bit;
  logic          scan_hit;
  logic          full;
  logic          drop_any;

  assign busy     = (state != S_IDLE);
  assign bit_val  = AW'(1) << idx;
  assign pool_bit = AW'(1) << pool_order;
  assign scan_hit = alu_fits && (count != '0);
  assign full     = (count == CW'(STACK_DEPTH));
  assign drop_any = dropped || (cmd.push && full);
  assign order    = idx;

  always_comb begin
    alu_a   = pos;
    alu_b   = bit_val;
    alu_sub = 1'b0;
    alu_lim = lim;
    cmd     = '0;
    wdata   = pos[LOG_BLOCKS-1:0];
    case (state)
      S_CHECK: begin
        alu_b   = AW'(size);
        alu_lim = pool_bit;
      end
      S_SCAN: begin
        alu_a   = AW'(size);
        alu_b   = '0;
        alu_lim = bit_val;
        cmd.pop = scan_hit;
      end
      S_SETUP: begin
        alu_a = AW'(rdata);
      end
      S_REST: begin
        alu_a   = bit_val;
        alu_b   = AW'(size);
        alu_sub = 1'b1;
      end
      S_SPLIT: begin
        alu_sub  = 1'b1;
        cmd.push = lim[idx];
        wdata    = alu_res[LOG_BLOCKS-1:0];
      end
      S_UP: begin
        cmd.push = pos[idx] && alu_fits;
      end
      S_DOWN: begin
        cmd.push = alu_fits;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op    <= req.op;
            size  <= req.size_blocks;
            pos   <= AW'(req.first_block);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          dropped <= 1'b0;
          idx     <= '0;
          if (size == '0) begin
            done            <= 1'b1;
            rsp.block_index <= '0;
            rsp.status      <= STATUS_BAD;
            state           <= S_IDLE;
          end else begin
            case (op)
              OP_ALLOC: state <= S_SCAN;
              OP_FREE: begin
                if (alu_fits) begin
                  lim   <= alu_res;
                  state <= S_UP;
                end else begin
                  done            <= 1'b1;
                  rsp.block_index <= '0;
                  rsp.status      <= STATUS_BAD;
                  state           <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            state <= S_SETUP;
          end else if (idx == pool_order) begin
            done            <= 1'b1;
            rsp.block_index <= '0;
            rsp.status      <= STATUS_NOFREE;
            state           <= S_IDLE;
          end else begin
            idx <= idx + OW'(1);
          end
        end
        S_SETUP: begin
          pos   <= alu_res;
          blk   <= rdata;
          state <= S_REST;
        end
        S_REST: begin
          lim <= alu_res;
          if (idx == '0) begin
            done            <= 1'b1;
            rsp.block_index <= INDEX_W'(blk);
            rsp.status      <= STATUS_OK;
            state           <= S_IDLE;
          end else begin
            idx   <= idx - OW'(1);
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (cmd.push) begin
            pos <= alu_res;
          end
          dropped <= drop_any;
          if (idx == '0) begin
            done            <= 1'b1;
            rsp.block_index <= INDEX_W'(blk);
            rsp.status      <= drop_any ? STATUS_DROP : STATUS_OK;
            state           <= S_IDLE;
          end else begin
            idx <= idx - OW'(1);
          end
        end
        S_UP: begin
          if (cmd.push) begin
            pos <= alu_res;
          end
          dropped <= drop_any;
          if (idx == OW'(LOG_BLOCKS - 1)) begin
            idx   <= OW'(LOG_BLOCKS);
            state <= S_DOWN;
          end else begin
            idx <= idx + OW'(1);
          end
        end
        S_DOWN: begin
          if (cmd.push) begin
            pos <= alu_res;
          end
          dropped <= drop_any;
          if (idx == '0) begin
            done            <= 1'b1;
            rsp.block_index <= '0;
            rsp.status      <= drop_any ? STATUS_DROP : STATUS_OK;
            state           <= S_IDLE;
          end else begin
            idx <= idx - OW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_push_pop: assert property (@(posedge clk) disable iff (rst) !(cmd.push && cmd.pop))
    else $error("push and pop in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0))
    else $error("pop from an empty stack");

  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == STATUS_NOFREE || rsp.status == STATUS_BAD))
      |-> (rsp.block_index == '0))
    else $error("failed request returned a nonzero block index");

endmodule

// ===== design/power_of_two_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_unit
// Buddy-style block pool with one free stack per order and no coalescing.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy then stays
// high until the result word appears on rsp with done high for exactly one
// cycle, and the receiver must take it then. A new start may be given in the
// same cycle as done. One shared adder/comparator is stepped one order per
// cycle: a free walks the orders up and then down, an allocate scans up for
// the first large enough order with a free chunk and splits it down to order 0,
// an allocate that finds nothing stops at pool_order, and a zero size or a
// range beyond the pool is answered from the check state. The user must write
// pool_order only while idle, which the block does not enforce; a write, like
// reset, sets the pool to one free chunk at block zero, with no clearing pass.
module power_of_two_block_allocator_unit import pba_pkg::*; #(
  parameter int LOG_BLOCKS  = LOG_BLOCKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             pool_order_we,
  input  logic [CFG_W-1:0] pool_order
);

  localparam int OW = $clog2(LOG_BLOCKS + 1);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (LOG_BLOCKS + 1 > SIZE_W + 1) ? LOG_BLOCKS + 1 : SIZE_W + 1;

  stk_cmd_t              cmd;
  logic [OW-1:0]         order;
  logic [LOG_BLOCKS-1:0] wdata;
  logic [CW-1:0]         count;
  logic [LOG_BLOCKS-1:0] rdata;
  logic [OW-1:0]         cur_order;
  logic [AW-1:0]         alu_a;
  logic [AW-1:0]         alu_b;
  logic                  alu_sub;
  logic [AW-1:0]         alu_lim;
  logic [AW-1:0]         alu_res;
  logic                  alu_fits;

  pba_store #(
    .LOG_BLOCKS  (LOG_BLOCKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_store (
    .clk              (clk),
    .rst              (rst),
    .pool_order_we    (pool_order_we),
    .pool_order_wdata (pool_order),
    .cmd              (cmd),
    .order            (order),
    .wdata            (wdata),
    .count            (count),
    .rdata            (rdata),
    .pool_order       (cur_order)
  );

  pba_alu #(
    .AW (AW)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .lim  (alu_lim),
    .res  (alu_res),
    .fits (alu_fits)
  );

  pba_seq #(
    .LOG_BLOCKS  (LOG_BLOCKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .pool_order (cur_order),
    .count      (count),
    .rdata      (rdata),
    .cmd        (cmd),
    .order      (order),
    .wdata      (wdata),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_sub    (alu_sub),
    .alu_lim    (alu_lim),
    .alu_res    (alu_res),
    .alu_fits   (alu_fits)
  );

endmodule
